// ===== rtl/line_edit_buffer_top_assert.svh =====
// Assertion macros used by the line edit buffer controller.
`ifndef LINE_EDIT_BUFFER_TOP_ASSERT_SVH
`define LINE_EDIT_BUFFER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LEB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/leb_pkg.sv =====
// Shared types and constants for the line edit buffer.
package leb_pkg;

  // Number of characters the buffer holds.
  localparam int CAPACITY = 64;
  // Width of a count that can hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Key codes with an editing meaning.
  localparam logic [7:0] KEY_HOME  = 8'h5B;
  localparam logic [7:0] KEY_END   = 8'h5D;
  localparam logic [7:0] KEY_BACK  = 8'h2D;
  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;

  // What a single cell loads on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_KEY,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_e;

  // Row-wide operation issued by the controller.
  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_DELETE,
    EDIT_SHIFT_OUT
  } edit_e;

  typedef struct packed {
    edit_e            kind;
    logic [CNT_W-1:0] cursor;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
  } emit_t;

endpackage

// ===== rtl/leb_cell.sv =====
// One character cell of the text row.
module leb_cell import leb_pkg::*; (
  input  logic       clk_i,
  input  cell_op_e   op_i,
  input  logic [7:0] key_i,
  input  logic [7:0] left_i,
  input  logic [7:0] right_i,
  output logic [7:0] data_o
);

  logic [7:0] data_d, data_q;

  // Select the new character from the key, a neighbour or the cell itself.
  always_comb begin
    unique case (op_i)
      CELL_KEY:   data_d = key_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  // Character storage carries no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/leb_ctrl.sv =====
// Cursor, length and flush sequencing for the line edit buffer.
`include "line_edit_buffer_top_assert.svh"

module leb_ctrl import leb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] key_byte_i,
  input  logic       finish_i,
  output logic       busy_o,
  output cmd_t       cmd_o,
  output emit_t      emit_o
);

  localparam logic ST_EDIT  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             state_d, state_q;
  logic [CNT_W-1:0] len_d, len_q;
  logic [CNT_W-1:0] cur_d, cur_q;
  logic [CNT_W-1:0] remain_d, remain_q;
  edit_e            kind;

  // Decode the accepted word, or step the flush one character.
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cur_d    = cur_q;
    remain_d = remain_q;
    kind     = EDIT_NONE;
    emit_o   = '0;
    if (state_q == ST_FLUSH) begin
      kind         = EDIT_SHIFT_OUT;
      emit_o.valid = 1'b1;
      emit_o.last  = (remain_q == CNT_W'(1));
      remain_d     = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        state_d = ST_EDIT;
      end
    end else if (accept_i) begin
      if (finish_i) begin
        // The row is sent out from cell zero; the counters clear at once.
        if (len_q != '0) begin
          state_d  = ST_FLUSH;
          remain_d = len_q;
        end
        len_d = '0;
        cur_d = '0;
      end else begin
        unique case (key_byte_i)
          KEY_HOME: cur_d = '0;
          KEY_END:  cur_d = len_q;
          KEY_BACK: begin
            if (cur_q != '0) begin
              kind  = EDIT_DELETE;
              cur_d = cur_q - CNT_W'(1);
              len_d = len_q - CNT_W'(1);
            end
          end
          KEY_LEFT: begin
            if (cur_q != '0) begin
              cur_d = cur_q - CNT_W'(1);
            end
          end
          KEY_RIGHT: begin
            if (cur_q < len_q) begin
              cur_d = cur_q + CNT_W'(1);
            end
          end
          default: begin
            // A full buffer drops the character.
            if (len_q < CAP_CNT) begin
              kind  = EDIT_INSERT;
              cur_d = cur_q + CNT_W'(1);
              len_d = len_q + CNT_W'(1);
            end
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_EDIT;
      len_q    <= '0;
      cur_q    <= '0;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cur_q    <= cur_d;
      remain_q <= remain_d;
    end
  end

  assign busy_o     = (state_q == ST_FLUSH);
  assign cmd_o.kind   = kind;
  assign cmd_o.cursor = cur_q;

  `LEB_ASSERT_ALWAYS(a_cursor_in_text, cur_q <= len_q, "cursor beyond end of text")
  `LEB_ASSERT_ALWAYS(a_len_in_range, len_q <= CAP_CNT, "text length beyond capacity")
  `LEB_ASSERT_ALWAYS(a_flush_count, !busy_o || (remain_q != '0 && len_q == '0),
    "flush running with bad counters")
  `LEB_ASSERT_NEXT(a_flush_ends, emit_o.valid && emit_o.last, !busy_o,
    "flush continued after the last word")

endmodule

// ===== rtl/line_edit_buffer_top.sv =====
// Top level of the line edit buffer: cell row, controller and output register.
// An edit word (any key with finish low) is taken without raising busy, so
// edits may be started on every cycle. A finish word with characters held
// raises busy from the edge that accepts it until the last character has left,
// while the cell row shifts one character out of cell zero per cycle into the
// output register. The words therefore appear on out_byte_o with out_strobe_o
// high for one cycle each, registered once behind busy: the first in the cycle
// after busy rises, the last one, with last_o high, in the first cycle in which
// busy is low again. The receiver cannot stall, so the output must be taken on
// the cycle it is strobed. A finish with an empty buffer produces no words and
// leaves busy low.
module line_edit_buffer_top import leb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] key_byte_i,
  input  logic       finish_i,
  output logic       out_strobe_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic       accept;
  cmd_t       cmd;
  emit_t      emit;
  logic [7:0] cell_data [CAPACITY];
  logic       strobe_q;
  logic       last_q;
  logic [7:0] out_byte_q;

  assign accept = start & ~busy;

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .key_byte_i (key_byte_i),
    .finish_i   (finish_i),
    .busy_o     (busy),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  // Row of cells; each decodes the row command against its own position.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CNT_W-1:0] POS      = CNT_W'(g);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(g + 1);
    cell_op_e   op;
    logic [7:0] left;
    logic [7:0] right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[g+1];
    end

    always_comb begin
      op = CELL_HOLD;
      unique case (cmd.kind)
        EDIT_INSERT: begin
          if (POS > cmd.cursor) begin
            op = CELL_LEFT;
          end else if (POS == cmd.cursor) begin
            op = CELL_KEY;
          end
        end
        EDIT_DELETE: begin
          if (POS_NEXT >= cmd.cursor) begin
            op = CELL_RIGHT;
          end
        end
        EDIT_SHIFT_OUT: op = CELL_RIGHT;
        default:        op = CELL_HOLD;
      endcase
    end

    leb_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .key_i   (key_byte_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  // Output word register fed from cell zero during a flush.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= emit.valid;
      last_q   <= emit.valid & emit.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_byte_q <= cell_data[0];
    end
  end

  assign out_strobe_o = strobe_q;
  assign last_o       = last_q;
  assign out_byte_o   = out_byte_q;

endmodule
